// ===== rtl/handle_release_tracking_table_core_defines.svh =====
// assertion macros used by the table core
`ifndef HANDLE_RELEASE_TRACKING_TABLE_CORE_DEFINES_SVH
`define HANDLE_RELEASE_TRACKING_TABLE_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define HRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define HRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hrtt_pkg.sv =====
`timescale 1ns / 1ps
package hrtt_pkg;

	localparam int unsigned KEY_W = 64;
	localparam int unsigned CNT_W = 7;

	typedef enum logic [1:0] {
		KIND_OBSERVE  = 2'd0,
		KIND_RETIRE   = 2'd1,
		KIND_BEGIN    = 2'd2,
		KIND_COMPLETE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REL_UNTRACKED   = 2'd0,
		REL_IN_FLIGHT   = 2'd1,
		REL_STARTED     = 2'd2,
		REL_NOT_RECORDED = 2'd3
	} rel_status_t;

	localparam logic [1:0] OUTCOME_SUCCESS = 2'd0;
	localparam logic [1:0] OUTCOME_FAILURE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RESULT
	} state_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic        valid;
		logic [63:0] owner;
		logic [63:0] handle;
		logic [63:0] observation;
		logic        retired;
		logic [63:0] attempt;
		logic [63:0] release_obs;
	} entry_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] owner_id;
		logic [63:0] handle_id;
		logic        retired_flag;
		logic [63:0] token_revision;
		logic [1:0]  release_outcome;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [1:0]  release_status;
		logic [63:0] granted_revision;
		logic [63:0] change_sequence;
		logic [6:0]  entry_count;
		logic [6:0]  residual_count;
		logic [63:0] release_successes;
		logic [63:0] release_failures;
		logic        coverage_complete;
	} rsp_t;

endpackage

// ===== rtl/hrtt_stream_if.sv =====
`timescale 1ns / 1ps
interface hrtt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/hrtt_ram.sv =====
`timescale 1ns / 1ps
module hrtt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/handle_release_tracking_table_core.sv =====
`timescale 1ns / 1ps
`include "handle_release_tracking_table_core_defines.svh"
// Handle release tracking table. Each word on req runs a scan over all
// TABLE_ENTRIES slots of the entry memory, one slot read per cycle, then a
// decision state and at most one slot write, after which the response word
// is registered; retire-owner also writes matching slots during the scan.
// The response word sits in an output register and the next request is taken
// only once that word has been taken, so the block does not take a new word
// while the last one is still in the scan or waiting at the output. After
// reset the block clears the valid bits of the memory before it takes the
// first word.
module handle_release_tracking_table_core #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	hrtt_stream_if.sink   req,
	hrtt_stream_if.source rsp
);
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned EW = $bits(hrtt_pkg::entry_t);
	localparam logic [AW:0] LAST = (AW + 1)'(TABLE_ENTRIES - 1);

	hrtt_pkg::state_t state_q, state_d;
	hrtt_pkg::req_t   req_q;
	hrtt_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic [AW:0]   idx_q;
	logic          clearing_q;
	logic          rd_valid_s1;
	logic [AW-1:0] rd_addr_s1;

	logic          found_q, free_q;
	logic [AW-1:0] found_idx_q, free_idx_q;
	hrtt_pkg::entry_t found_ent_q;
	logic          retire_chg_q;

	logic [63:0] rev_q, seq_q, succ_q, fail_q;
	logic        complete_q;
	logic [6:0]  live_q, retc_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	hrtt_pkg::entry_t mem_wdata, mem_rdata;

	hrtt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready = (state_q == hrtt_pkg::ST_IDLE) && !clearing_q && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	wire accept_w  = req.valid && req.ready;
	wire rsp_take  = rsp_valid_q && rsp.ready;
	wire scan_last = (idx_q == LAST);

	// key match on the word read in the previous cycle
	wire hit_w = rd_valid_s1 && mem_rdata.valid && mem_rdata.owner == req_q.owner_id
		&& mem_rdata.handle == req_q.handle_id;
	wire retire_hit_w = rd_valid_s1 && (req_q.kind == hrtt_pkg::KIND_RETIRE)
		&& mem_rdata.valid && mem_rdata.owner == req_q.owner_id && !mem_rdata.retired;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hrtt_pkg::ST_IDLE:   if (accept_w) state_d = hrtt_pkg::ST_SCAN;
			hrtt_pkg::ST_SCAN:   if (scan_last) state_d = hrtt_pkg::ST_DECIDE;
			hrtt_pkg::ST_DECIDE: state_d = hrtt_pkg::ST_RESULT;
			hrtt_pkg::ST_RESULT: state_d = hrtt_pkg::ST_IDLE;
			default:             state_d = hrtt_pkg::ST_IDLE;
		endcase
	end

	// decision on the scanned entry
	logic        d_we;
	logic [AW-1:0] d_addr;
	hrtt_pkg::entry_t d_ent;
	logic        d_acc;
	logic [1:0]  d_status;
	logic [63:0] d_grant, d_rev, d_seq, d_succ, d_fail;
	logic        d_complete;
	logic [6:0]  d_live, d_retc;

	always_comb begin
		d_we = 1'b0;
		d_addr = found_idx_q;
		d_ent = found_ent_q;
		d_acc = 1'b0;
		d_status = hrtt_pkg::REL_UNTRACKED;
		d_grant = '0;
		d_rev = rev_q;
		d_seq = seq_q;
		d_succ = succ_q;
		d_fail = fail_q;
		d_complete = complete_q;
		d_live = live_q;
		d_retc = retc_q;
		case (hrtt_pkg::kind_t'(req_q.kind))
			hrtt_pkg::KIND_OBSERVE: begin
				if (req_q.owner_id != '0 && req_q.handle_id != '0) begin
					if (rev_q == '1) begin
						d_complete = 1'b0;
					end else begin
						d_rev = rev_q + 64'd1;
						if (!found_q && !free_q) begin
							d_complete = 1'b0;
						end else begin
							if (!found_q) begin
								d_addr = free_idx_q;
								d_ent.valid = 1'b1;
								d_ent.owner = req_q.owner_id;
								d_ent.handle = req_q.handle_id;
								d_ent.retired = 1'b0;
								d_ent.attempt = '0;
								d_ent.release_obs = '0;
								d_live = live_q + 7'd1;
							end
							d_ent.observation = d_rev;
							if (req_q.retired_flag && !d_ent.retired) begin
								d_ent.retired = 1'b1;
								d_retc = retc_q + 7'd1;
							end
							d_we = 1'b1;
							d_acc = 1'b1;
							d_seq = seq_q + 64'd1;
						end
					end
				end
			end
			hrtt_pkg::KIND_RETIRE: begin
				if (retire_chg_q) d_seq = seq_q + 64'd1;
			end
			hrtt_pkg::KIND_BEGIN: begin
				if (found_q) begin
					if (found_ent_q.attempt != '0) begin
						d_status = hrtt_pkg::REL_IN_FLIGHT;
					end else if (rev_q == '1) begin
						d_complete = 1'b0;
						d_status = hrtt_pkg::REL_NOT_RECORDED;
					end else begin
						d_rev = rev_q + 64'd1;
						d_ent.attempt = d_rev;
						d_ent.release_obs = found_ent_q.observation;
						d_we = 1'b1;
						d_seq = seq_q + 64'd1;
						d_grant = d_rev;
						d_status = hrtt_pkg::REL_STARTED;
					end
				end
			end
			default: begin
				if (req_q.token_revision != '0 && found_q
					&& found_ent_q.attempt == req_q.token_revision) begin
					d_ent.attempt = '0;
					d_we = 1'b1;
					d_seq = seq_q + 64'd1;
					if (req_q.release_outcome == hrtt_pkg::OUTCOME_SUCCESS) begin
						d_succ = succ_q + 64'd1;
						if (found_ent_q.observation == found_ent_q.release_obs) begin
							d_ent.valid = 1'b0;
							d_live = live_q - 7'd1;
							if (found_ent_q.retired) d_retc = retc_q - 7'd1;
						end
					end else if (req_q.release_outcome == hrtt_pkg::OUTCOME_FAILURE) begin
						d_fail = fail_q + 64'd1;
					end
				end
			end
		endcase
	end

	// memory port control
	always_comb begin
		mem_raddr = idx_q[AW-1:0];
		mem_we = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = mem_rdata;
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_waddr = idx_q[AW-1:0];
			mem_wdata = '0;
		end else if (retire_hit_w) begin
			mem_we = 1'b1;
			mem_wdata.retired = 1'b1;
		end else if (state_q == hrtt_pkg::ST_RESULT && d_we) begin
			mem_we = 1'b1;
			mem_waddr = d_addr;
			mem_wdata = d_ent;
		end
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrtt_pkg::ST_IDLE;
			clearing_q <= 1'b1;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			rev_q <= '0;
			seq_q <= '0;
			succ_q <= '0;
			fail_q <= '0;
			complete_q <= 1'b1;
			live_q <= '0;
			retc_q <= '0;
		end else begin
			state_q <= state_d;
			rd_valid_s1 <= (state_q == hrtt_pkg::ST_SCAN);
			if (clearing_q) begin
				if (scan_last) begin
					clearing_q <= 1'b0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (state_q == hrtt_pkg::ST_SCAN) begin
				idx_q <= scan_last ? '0 : idx_q + 1'b1;
			end
			if (retire_hit_w) retc_q <= retc_q + 7'd1;
			if (state_q == hrtt_pkg::ST_RESULT) begin
				rev_q <= d_rev;
				seq_q <= d_seq;
				succ_q <= d_succ;
				fail_q <= d_fail;
				complete_q <= d_complete;
				live_q <= d_live;
				retc_q <= d_retc;
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// scan bookkeeping and the response payload
	always_ff @(posedge clk) begin
		if (accept_w) begin
			req_q <= req.data;
			found_q <= 1'b0;
			free_q <= 1'b0;
			retire_chg_q <= 1'b0;
		end
		rd_addr_s1 <= idx_q[AW-1:0];
		if (hit_w && !found_q) begin
			found_q <= 1'b1;
			found_idx_q <= rd_addr_s1;
			found_ent_q <= mem_rdata;
		end
		if (rd_valid_s1 && !mem_rdata.valid && !free_q) begin
			free_q <= 1'b1;
			free_idx_q <= rd_addr_s1;
		end
		if (retire_hit_w) retire_chg_q <= 1'b1;
		if (state_q == hrtt_pkg::ST_RESULT) begin
			rsp_q.accepted <= d_acc;
			rsp_q.release_status <= d_status;
			rsp_q.granted_revision <= d_grant;
			rsp_q.change_sequence <= d_seq;
			rsp_q.entry_count <= d_live;
			rsp_q.residual_count <= d_retc;
			rsp_q.release_successes <= d_succ;
			rsp_q.release_failures <= d_fail;
			rsp_q.coverage_complete <= d_complete;
		end
	end

	`HRT_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != hrtt_pkg::ST_IDLE, !req.ready, "request taken while busy")
	`HRT_ASSERT_IMP(a_live_bound, clk, arst_n, 1'b1, retc_q <= live_q, "retired count above live count")
	`HRT_ASSERT_NEXT(a_result_sets_valid, clk, arst_n, state_q == hrtt_pkg::ST_RESULT, rsp_valid_q, "response missing after decision")
	`HRT_ASSERT_IMP(a_no_scan_clear, clk, arst_n, clearing_q, state_q == hrtt_pkg::ST_IDLE, "scan during clearing pass")

endmodule

// ===== tb/sv/handle_release_tracking_table_core_test.sv =====
`timescale 1ns / 1ps
module handle_release_tracking_table_core_test;
	import hrtt_pkg::*;

	localparam int unsigned SLOTS = 64;
	localparam int unsigned RANDOM_WORDS = 1800;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned DRAIN_CYCLES = 3 * SLOTS;
	localparam logic [1:0] OUTCOME_NEITHER = 2'd2;
	localparam logic [1:0] OUTCOME_SPARE = 2'd3;

	logic clk;
	logic arst_n;

	hrtt_stream_if #(.T(req_t)) req_ch ();
	hrtt_stream_if #(.T(rsp_t)) rsp_ch ();

	handle_release_tracking_table_core #(.TABLE_ENTRIES(SLOTS)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// shadow copy of the table
	logic        tbl_valid [SLOTS];
	logic [63:0] tbl_owner [SLOTS];
	logic [63:0] tbl_handle [SLOTS];
	logic [63:0] tbl_obs [SLOTS];
	logic        tbl_retired [SLOTS];
	logic [63:0] tbl_attempt [SLOTS];
	logic [63:0] tbl_rel_obs [SLOTS];
	logic [63:0] revision;
	logic [63:0] change_seq;
	logic [63:0] successes;
	logic [63:0] failures;
	logic        still_complete;
	logic [6:0]  live_entries;
	logic [6:0]  retired_entries;

	rsp_t        pending_rsp [$];
	logic [63:0] recent_grants [16];
	int unsigned grant_ptr;
	int unsigned mismatches;
	int unsigned cycles;
	bit          receiver_hold;
	bit          no_idle;

	// directed table
	typedef struct {
		req_t w;
		bit   typed;
		rsp_t r;
	} row_t;
	row_t rows [$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic req_t mk(kind_t k, logic [63:0] o, logic [63:0] h, logic rf,
			logic [63:0] tok, logic [1:0] oc);
		req_t w;
		w.kind = k;
		w.owner_id = o;
		w.handle_id = h;
		w.retired_flag = rf;
		w.token_revision = tok;
		w.release_outcome = oc;
		return w;
	endfunction

	function automatic rsp_t mk_rsp(logic acc, rel_status_t st, logic [63:0] gr,
			logic [63:0] sq, logic [6:0] ec, logic [6:0] rc, logic [63:0] sc,
			logic [63:0] fc, logic cov);
		rsp_t r;
		r.accepted = acc;
		r.release_status = st;
		r.granted_revision = gr;
		r.change_sequence = sq;
		r.entry_count = ec;
		r.residual_count = rc;
		r.release_successes = sc;
		r.release_failures = fc;
		r.coverage_complete = cov;
		return r;
	endfunction

	function automatic int lookup(logic [63:0] o, logic [63:0] h);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_owner[i] == o && tbl_handle[i] == h)
				return i;
		return -1;
	endfunction

	function automatic logic [63:0] take_revision();
		if (revision == '1) begin
			still_complete = 1'b0;
			return '0;
		end
		revision = revision + 64'd1;
		return revision;
	endfunction

	// predicted response for one accepted request
	function automatic rsp_t track_request(req_t w);
		rsp_t r;
		logic [63:0] rev;
		int s;
		bit changed;
		r = '0;
		case (kind_t'(w.kind))
			KIND_OBSERVE: begin
				if (w.owner_id != 0 && w.handle_id != 0) begin
					rev = take_revision();
					if (rev != 0) begin
						s = lookup(w.owner_id, w.handle_id);
						if (s < 0) begin
							for (int i = 0; i < SLOTS; i++)
								if (!tbl_valid[i] && s < 0)
									s = i;
							if (s < 0) begin
								still_complete = 1'b0;
							end else begin
								tbl_valid[s] = 1'b1;
								tbl_owner[s] = w.owner_id;
								tbl_handle[s] = w.handle_id;
								tbl_retired[s] = 1'b0;
								tbl_attempt[s] = '0;
								tbl_rel_obs[s] = '0;
								live_entries = live_entries + 7'd1;
							end
						end
						if (s >= 0) begin
							tbl_obs[s] = rev;
							if (w.retired_flag && !tbl_retired[s]) begin
								tbl_retired[s] = 1'b1;
								retired_entries = retired_entries + 7'd1;
							end
							change_seq = change_seq + 64'd1;
							r.accepted = 1'b1;
						end
					end
				end
			end
			KIND_RETIRE: begin
				changed = 0;
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i] && tbl_owner[i] == w.owner_id && !tbl_retired[i]) begin
						tbl_retired[i] = 1'b1;
						retired_entries = retired_entries + 7'd1;
						changed = 1;
					end
				if (changed)
					change_seq = change_seq + 64'd1;
			end
			KIND_BEGIN: begin
				s = lookup(w.owner_id, w.handle_id);
				if (s < 0) begin
					r.release_status = REL_UNTRACKED;
				end else if (tbl_attempt[s] != 0) begin
					r.release_status = REL_IN_FLIGHT;
				end else begin
					rev = take_revision();
					if (rev == 0) begin
						r.release_status = REL_NOT_RECORDED;
					end else begin
						tbl_attempt[s] = rev;
						tbl_rel_obs[s] = tbl_obs[s];
						change_seq = change_seq + 64'd1;
						r.release_status = REL_STARTED;
						r.granted_revision = rev;
						recent_grants[grant_ptr] = rev;
						grant_ptr = (grant_ptr + 1) % 16;
					end
				end
			end
			default: begin
				s = lookup(w.owner_id, w.handle_id);
				if (w.token_revision != 0 && s >= 0 && tbl_attempt[s] == w.token_revision) begin
					tbl_attempt[s] = '0;
					change_seq = change_seq + 64'd1;
					if (w.release_outcome == OUTCOME_SUCCESS) begin
						successes = successes + 64'd1;
						if (tbl_obs[s] == tbl_rel_obs[s]) begin
							tbl_valid[s] = 1'b0;
							live_entries = live_entries - 7'd1;
							if (tbl_retired[s])
								retired_entries = retired_entries - 7'd1;
						end
					end else if (w.release_outcome == OUTCOME_FAILURE) begin
						failures = failures + 64'd1;
					end
				end
			end
		endcase
		r.change_sequence = change_seq;
		r.entry_count = live_entries;
		r.residual_count = retired_entries;
		r.release_successes = successes;
		r.release_failures = failures;
		r.coverage_complete = still_complete;
		return r;
	endfunction

	// random request, mostly on a small key space so the table fills and matches
	function automatic req_t random_request();
		req_t w;
		int unsigned pick;
		w.kind = kind_t'($urandom_range(0, 99) < 40 ? KIND_OBSERVE :
			($urandom_range(0, 99) < 15 ? KIND_RETIRE :
			($urandom_range(0, 1) ? KIND_BEGIN : KIND_COMPLETE)));
		if ($urandom_range(0, 15) == 0) begin
			w.owner_id = {$urandom, $urandom};
			w.handle_id = {$urandom, $urandom};
		end else begin
			w.owner_id = 64'($urandom_range(1, 10));
			w.handle_id = 64'($urandom_range(1, 8));
		end
		if ($urandom_range(0, 29) == 0)
			w.owner_id = '0;
		if ($urandom_range(0, 29) == 0)
			w.handle_id = '0;
		w.retired_flag = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			w.token_revision = '0;
		else if (pick == 1)
			w.token_revision = {$urandom, $urandom};
		else
			w.token_revision = recent_grants[$urandom_range(0, 15)];
		w.release_outcome = $urandom_range(0, 99) < 45 ? OUTCOME_SUCCESS :
			($urandom_range(0, 2) == 0 ? OUTCOME_FAILURE : 2'($urandom_range(2, 3)));
		return w;
	endfunction

	function automatic int unsigned idle_cycles();
		return no_idle ? 0 : $urandom_range(0, 7);
	endfunction

	// offer one word and wait for it to be taken
	task automatic send_word(req_t w, bit typed, rsp_t r);
		int unsigned gap;
		rsp_t p;
		gap = idle_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.data <= w;
		req_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		p = track_request(w);
		pending_rsp.push_back(typed ? r : p);
		@(negedge clk);
	endtask

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver side
	initial begin
		int unsigned gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = idle_cycles();
			if (receiver_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				receiver_hold = 0;
			end else if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(rsp_ch.valid && rsp_ch.ready));
			@(negedge clk);
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t e;
		rsp_t a;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			a = rsp_ch.data;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word %p", a);
			end else begin
				e = pending_rsp.pop_front();
				if (a.accepted !== e.accepted || a.release_status !== e.release_status
						|| a.granted_revision !== e.granted_revision
						|| a.change_sequence !== e.change_sequence
						|| a.entry_count !== e.entry_count
						|| a.residual_count !== e.residual_count
						|| a.release_successes !== e.release_successes
						|| a.release_failures !== e.release_failures
						|| a.coverage_complete !== e.coverage_complete) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: expected %p got %p", e, a);
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		mismatches = 0;
		receiver_hold = 0;
		no_idle = 0;
		grant_ptr = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_owner[i] = '0;
			tbl_handle[i] = '0;
			tbl_obs[i] = '0;
			tbl_retired[i] = 1'b0;
			tbl_attempt[i] = '0;
			tbl_rel_obs[i] = '0;
		end
		for (int i = 0; i < 16; i++)
			recent_grants[i] = '0;
		revision = '0;
		change_seq = '0;
		successes = '0;
		failures = '0;
		still_complete = 1'b1;
		live_entries = '0;
		retired_entries = '0;

		// typed rows: reset values, extreme keys, one full release cycle
		rows.push_back('{mk(KIND_COMPLETE, 64'd3, 64'd3, 1'b0, 64'd0, OUTCOME_SUCCESS), 1,
			mk_rsp(0, REL_UNTRACKED, 0, 0, 0, 0, 0, 0, 1)});
		rows.push_back('{mk(KIND_OBSERVE, 64'd0, 64'd5, 1'b1, 64'd0, OUTCOME_SUCCESS), 1,
			mk_rsp(0, REL_UNTRACKED, 0, 0, 0, 0, 0, 0, 1)});
		rows.push_back('{mk(KIND_OBSERVE, '1, '1, 1'b1, '1, OUTCOME_SPARE), 1,
			mk_rsp(1, REL_UNTRACKED, 0, 1, 1, 1, 0, 0, 1)});
		rows.push_back('{mk(KIND_BEGIN, '1, '1, 1'b0, 64'd0, OUTCOME_SUCCESS), 1,
			mk_rsp(0, REL_STARTED, 2, 2, 1, 1, 0, 0, 1)});
		rows.push_back('{mk(KIND_BEGIN, '1, '1, 1'b1, '1, OUTCOME_SPARE), 1,
			mk_rsp(0, REL_IN_FLIGHT, 0, 2, 1, 1, 0, 0, 1)});
		rows.push_back('{mk(KIND_COMPLETE, '1, '1, 1'b0, 64'd2, OUTCOME_SUCCESS), 1,
			mk_rsp(0, REL_UNTRACKED, 0, 3, 0, 0, 1, 0, 1)});
		rows.push_back('{mk(KIND_BEGIN, 64'd7, 64'd7, 1'b0, 64'd0, OUTCOME_SUCCESS), 1,
			mk_rsp(0, REL_UNTRACKED, 0, 3, 0, 0, 1, 0, 1)});
		// predicted rows: retire, refresh during release, stale tokens, outcomes
		rows.push_back('{mk(KIND_OBSERVE, 64'd7, 64'd1, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_OBSERVE, 64'd7, 64'd2, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_RETIRE, 64'd7, 64'd0, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_RETIRE, 64'd7, 64'd9, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_BEGIN, 64'd7, 64'd1, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_OBSERVE, 64'd7, 64'd1, 1'b1, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_COMPLETE, 64'd7, 64'd1, 1'b0, 64'd5, OUTCOME_SUCCESS), 0, '0});
		rows.push_back('{mk(KIND_COMPLETE, 64'd7, 64'd1, 1'b0, 64'd5, OUTCOME_SUCCESS), 0, '0});
		rows.push_back('{mk(KIND_BEGIN, 64'd7, 64'd2, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_COMPLETE, 64'd7, 64'd2, 1'b0, 64'd7, OUTCOME_FAILURE), 0, '0});
		rows.push_back('{mk(KIND_BEGIN, 64'd7, 64'd2, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_COMPLETE, 64'd7, 64'd2, 1'b0, 64'd8, OUTCOME_NEITHER), 0, '0});
		rows.push_back('{mk(KIND_BEGIN, 64'd7, 64'd1, 1'b0, 0, 0), 0, '0});
		rows.push_back('{mk(KIND_COMPLETE, 64'd7, 64'd1, 1'b0, 64'd9, OUTCOME_SPARE), 0, '0});
		rows.push_back('{mk(KIND_COMPLETE, 64'd8, 64'd1, 1'b0, 64'd9, OUTCOME_SUCCESS), 0, '0});
		rows.push_back('{mk(KIND_OBSERVE, 64'd5, 64'd0, 1'b0, 0, 0), 0, '0});

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].r);

		// random words in phases: normal, back to back, long receiver stall, pause
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			no_idle = (n / 150) % 4 == 1;
			if (n == 600)
				receiver_hold = 1;
			if (n == 1000) begin
				req_ch.valid <= 1'b0;
				while (pending_rsp.size() != 0)
					@(negedge clk);
			end
			send_word(random_request(), 0, '0);
		end
		req_ch.valid <= 1'b0;

		// drain
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
